// ----- rtl/lfrc_pkg.sv -----
package lfrc_pkg;

    // Motor direction codes
    typedef logic [1:0] t_dir;
    localparam t_dir DIR_STOP = 2'd0;
    localparam t_dir DIR_FWD  = 2'd1;
    localparam t_dir DIR_BACK = 2'd2;

    // Route phase as shown on the result beat
    typedef enum logic [2:0] {
        PH_OUTBOUND   = 3'd0,
        PH_TURNAROUND = 3'd1,
        PH_RETURN     = 3'd2,
        PH_PIVOT      = 3'd3,
        PH_FINISHED   = 3'd4
    } t_phase;

    // Configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CRUISE_SPEED    = 3'd0;
    localparam t_cfg_idx CFG_INNER_SPEED     = 3'd1;
    localparam t_cfg_idx CFG_OUTER_SPEED     = 3'd2;
    localparam t_cfg_idx CFG_U_TURN_TICKS    = 3'd3;
    localparam t_cfg_idx CFG_PIVOT_TICKS     = 3'd4;
    localparam t_cfg_idx CFG_DEBOUNCE_TICKS  = 3'd5;
    localparam t_cfg_idx CFG_COOLDOWN_TICKS  = 3'd6;
    localparam t_cfg_idx CFG_PIVOT_LINE_MASK = 3'd7;

    // Configuration reset values
    localparam logic [4:0]  RST_CRUISE_SPEED    = 5'd9;
    localparam logic [4:0]  RST_INNER_SPEED     = 5'd4;
    localparam logic [4:0]  RST_OUTER_SPEED     = 5'd5;
    localparam logic [11:0] RST_U_TURN_TICKS    = 12'd600;
    localparam logic [11:0] RST_PIVOT_TICKS     = 12'd140;
    localparam logic [7:0]  RST_DEBOUNCE_TICKS  = 8'd20;
    localparam logic [7:0]  RST_COOLDOWN_TICKS  = 8'd100;
    localparam logic [31:0] RST_PIVOT_LINE_MASK = 32'd52224;

    // Saturation limits
    localparam logic [4:0] CROSS_MAX    = 5'd31;
    localparam logic [7:0] DEBOUNCE_MAX = 8'd255;

    // Result beat packing
    typedef struct packed {
        logic [1:0] pad;
        t_phase     phase;
        logic [4:0] line_count;
        t_dir       right_dir;
        t_dir       left_dir;
        logic       right_pwm;
        logic       left_pwm;
    } t_result;

endpackage

// ----- rtl/line_follower_route_controller_core.sv -----
// A result beat is registered and presented in the cycle after its sensor beat is accepted.
// Throughput: one sensor beat per cycle; the single result register refills in the
//   same cycle it is drained, so input stalls only while the result waits unread.
// Reset (i_rst_n low, synchronous): all route, debounce and PWM state clears,
//   configuration returns to its default values and no result beat is pending.
module line_follower_route_controller_core #(
    parameter int PWM_PERIOD      = 20,
    parameter int TURNAROUND_LINE = 8,
    parameter int FINISH_LINE     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sensor beat
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [0] left_sensor, [1] right_sensor, [7:2] zero
    // result beat
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // [0] left_pwm, [1] right_pwm, [3:2] left_dir,
                                         // [5:4] right_dir, [10:6] line_count,
                                         // [13:11] phase, [15:14] zero
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam logic [4:0] PERIOD_C = 5'(PWM_PERIOD);
    localparam logic [4:0] TURN_C   = 5'(TURNAROUND_LINE);
    localparam logic [4:0] FINISH_C = 5'(FINISH_LINE);

    // Configuration registers
    logic [4:0]  r_cruise, r_inner, r_outer;
    logic [11:0] r_uturn_ticks, r_pivot_ticks;
    logic [7:0]  r_debounce_ticks, r_cooldown_ticks;
    logic [31:0] r_mask;

    // Route state
    logic [4:0]          r_pwm_cnt, n_pwm_cnt;
    logic [4:0]          r_ldrive, n_ldrive, r_rdrive, n_rdrive;
    lfrc_pkg::t_dir      r_ldir, n_ldir, r_rdir, n_rdir;
    logic [4:0]          r_cross, n_cross;
    logic                r_seen, n_seen, r_just, n_just;
    logic [7:0]          r_deb, n_deb, r_cool, n_cool;
    logic                r_turn, n_turn, r_piv, n_piv;
    logic [11:0]         r_turn_tmr, n_turn_tmr, r_piv_tmr, n_piv_tmr;
    logic                r_ret, n_ret, r_piv_done, n_piv_done;

    // Result register
    logic                r_out_valid;
    lfrc_pkg::t_result   r_out, n_out;

    logic accept;
    logic sen_l, sen_r;
    logic [4:0] cnt1;
    logic fin_now, fin_next;
    logic [7:0] deb_inc;

    assign sen_l = i_s_axis_tdata[0];
    assign sen_r = i_s_axis_tdata[1];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    // Hold configuration; writes land whenever the enable is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cruise         <= lfrc_pkg::RST_CRUISE_SPEED;
            r_inner          <= lfrc_pkg::RST_INNER_SPEED;
            r_outer          <= lfrc_pkg::RST_OUTER_SPEED;
            r_uturn_ticks    <= lfrc_pkg::RST_U_TURN_TICKS;
            r_pivot_ticks    <= lfrc_pkg::RST_PIVOT_TICKS;
            r_debounce_ticks <= lfrc_pkg::RST_DEBOUNCE_TICKS;
            r_cooldown_ticks <= lfrc_pkg::RST_COOLDOWN_TICKS;
            r_mask           <= lfrc_pkg::RST_PIVOT_LINE_MASK;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lfrc_pkg::CFG_CRUISE_SPEED:    r_cruise         <= i_cfg_data[4:0];
                lfrc_pkg::CFG_INNER_SPEED:     r_inner          <= i_cfg_data[4:0];
                lfrc_pkg::CFG_OUTER_SPEED:     r_outer          <= i_cfg_data[4:0];
                lfrc_pkg::CFG_U_TURN_TICKS:    r_uturn_ticks    <= i_cfg_data[11:0];
                lfrc_pkg::CFG_PIVOT_TICKS:     r_pivot_ticks    <= i_cfg_data[11:0];
                lfrc_pkg::CFG_DEBOUNCE_TICKS:  r_debounce_ticks <= i_cfg_data[7:0];
                lfrc_pkg::CFG_COOLDOWN_TICKS:  r_cooldown_ticks <= i_cfg_data[7:0];
                lfrc_pkg::CFG_PIVOT_LINE_MASK: r_mask           <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Work out the next tick from the current state and the sensor pair
    always_comb begin
        n_ldrive   = r_ldrive;
        n_rdrive   = r_rdrive;
        n_ldir     = r_ldir;
        n_rdir     = r_rdir;
        n_cross    = r_cross;
        n_seen     = r_seen;
        n_just     = r_just;
        n_deb      = r_deb;
        n_cool     = r_cool;
        n_turn     = r_turn;
        n_turn_tmr = r_turn_tmr;
        n_piv      = r_piv;
        n_piv_tmr  = r_piv_tmr;
        n_ret      = r_ret;
        n_piv_done = r_piv_done;
        deb_inc    = r_deb;

        // advance the PWM counter, compare against last tick's drive
        cnt1      = r_pwm_cnt + 5'd1;
        n_pwm_cnt = (cnt1 >= PERIOD_C) ? 5'd0 : cnt1;

        fin_now = r_ret && (r_cross >= FINISH_C);

        if (!fin_now) begin
            if (r_turn) begin
                n_ldrive   = r_cruise;
                n_rdrive   = r_cruise;
                n_ldir     = lfrc_pkg::DIR_FWD;
                n_rdir     = lfrc_pkg::DIR_BACK;
                n_turn_tmr = r_turn_tmr + 12'd1;
                if (n_turn_tmr >= r_uturn_ticks || n_turn_tmr == 12'd0) begin
                    n_turn = 1'b0;
                    n_ret  = 1'b1;
                end
            end else if (r_piv) begin
                n_ldrive  = r_cruise;
                n_rdrive  = r_cruise;
                n_ldir    = lfrc_pkg::DIR_BACK;
                n_rdir    = lfrc_pkg::DIR_FWD;
                n_piv_tmr = r_piv_tmr + 12'd1;
                if (n_piv_tmr >= r_pivot_ticks || n_piv_tmr == 12'd0) begin
                    n_piv     = 1'b0;
                    n_piv_tmr = 12'd0;
                    n_seen    = 1'b0;
                    n_just    = 1'b0;
                    n_deb     = 8'd0;
                    n_cool    = 8'd0;
                end
            end else if (!sen_l && !sen_r) begin
                // both on the line: arm the crossing
                n_ldrive = r_cruise;
                n_rdrive = r_cruise;
                n_ldir   = lfrc_pkg::DIR_FWD;
                n_rdir   = lfrc_pkg::DIR_FWD;
                n_seen   = 1'b1;
                n_just   = 1'b0;
                n_deb    = 8'd0;
            end else if (!sen_l) begin
                n_ldrive = r_outer;
                n_rdrive = r_inner;
                n_ldir   = lfrc_pkg::DIR_FWD;
                n_rdir   = lfrc_pkg::DIR_BACK;
                n_just   = 1'b0;
                n_deb    = 8'd0;
            end else if (!sen_r) begin
                n_ldrive = r_inner;
                n_rdrive = r_outer;
                n_ldir   = lfrc_pkg::DIR_BACK;
                n_rdir   = lfrc_pkg::DIR_FWD;
                n_just   = 1'b0;
                n_deb    = 8'd0;
            end else begin
                n_ldrive = r_cruise;
                n_rdrive = r_cruise;
                n_ldir   = lfrc_pkg::DIR_FWD;
                n_rdir   = lfrc_pkg::DIR_FWD;
                if (r_cool != 8'd0) begin
                    n_cool = r_cool - 8'd1;
                    n_deb  = 8'd0;
                end else if (r_seen && !r_just) begin
                    deb_inc = (r_deb < lfrc_pkg::DEBOUNCE_MAX) ? r_deb + 8'd1 : r_deb;
                    n_deb   = deb_inc;
                    if (deb_inc >= r_debounce_ticks) begin
                        // count the crossing and start the cooldown, unless a turnaround begins
                        n_cross = (r_cross < lfrc_pkg::CROSS_MAX) ? r_cross + 5'd1
                                                                  : r_cross;
                        n_seen  = 1'b0;
                        n_just  = 1'b1;
                        n_cool  = r_cooldown_ticks;
                        n_deb   = 8'd0;
                        if (!r_ret && n_cross >= TURN_C) begin
                            n_turn     = 1'b1;
                            n_turn_tmr = 12'd0;
                            n_seen     = 1'b0;
                            n_just     = 1'b0;
                            n_cool     = 8'd0;
                        end else if (r_ret && !r_piv_done && r_mask[n_cross]) begin
                            n_piv      = 1'b1;
                            n_piv_tmr  = 12'd0;
                            n_piv_done = 1'b1;
                        end
                        if (!r_mask[n_cross]) begin
                            n_piv_done = 1'b0;
                        end
                    end
                end else if (!r_seen) begin
                    n_deb = 8'd0;
                end
            end
        end

        // latch the stop once the finish line is reached on the way back
        fin_next = n_ret && (n_cross >= FINISH_C);
        if (fin_next) begin
            n_ldrive = 5'd0;
            n_rdrive = 5'd0;
            n_ldir   = lfrc_pkg::DIR_STOP;
            n_rdir   = lfrc_pkg::DIR_STOP;
        end

        n_out.pad        = 2'b00;
        n_out.left_pwm   = (cnt1 <= r_ldrive);
        n_out.right_pwm  = (cnt1 <= r_rdrive);
        n_out.left_dir   = n_ldir;
        n_out.right_dir  = n_rdir;
        n_out.line_count = n_cross;
        if (fin_next) begin
            n_out.phase = lfrc_pkg::PH_FINISHED;
        end else if (n_turn) begin
            n_out.phase = lfrc_pkg::PH_TURNAROUND;
        end else if (n_piv) begin
            n_out.phase = lfrc_pkg::PH_PIVOT;
        end else if (n_ret) begin
            n_out.phase = lfrc_pkg::PH_RETURN;
        end else begin
            n_out.phase = lfrc_pkg::PH_OUTBOUND;
        end
    end

    // Advance state on each accepted sensor beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_cnt  <= 5'd0;
            r_ldrive   <= 5'd0;
            r_rdrive   <= 5'd0;
            r_ldir     <= lfrc_pkg::DIR_STOP;
            r_rdir     <= lfrc_pkg::DIR_STOP;
            r_cross    <= 5'd0;
            r_seen     <= 1'b0;
            r_just     <= 1'b0;
            r_deb      <= 8'd0;
            r_cool     <= 8'd0;
            r_turn     <= 1'b0;
            r_turn_tmr <= 12'd0;
            r_piv      <= 1'b0;
            r_piv_tmr  <= 12'd0;
            r_ret      <= 1'b0;
            r_piv_done <= 1'b0;
        end else if (accept) begin
            r_pwm_cnt  <= n_pwm_cnt;
            r_ldrive   <= n_ldrive;
            r_rdrive   <= n_rdrive;
            r_ldir     <= n_ldir;
            r_rdir     <= n_rdir;
            r_cross    <= n_cross;
            r_seen     <= n_seen;
            r_just     <= n_just;
            r_deb      <= n_deb;
            r_cool     <= n_cool;
            r_turn     <= n_turn;
            r_turn_tmr <= n_turn_tmr;
            r_piv      <= n_piv;
            r_piv_tmr  <= n_piv_tmr;
            r_ret      <= n_ret;
            r_piv_done <= n_piv_done;
        end
    end

    // Hold the result beat until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- rtl/lfrc_checker.sv -----
module lfrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);

    logic [2:0] phase;
    assign phase = o_m_axis_tdata[13:11];

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // Never block input while the result register is empty
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with no result pending");

    // Finished beats show both motor directions stopped
    a_finished_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && phase == lfrc_pkg::PH_FINISHED |->
            o_m_axis_tdata[5:2] == 4'd0)
        else $error("motors running after finish");

    // Finish is latched: no later beat leaves it
    a_finished_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && phase == lfrc_pkg::PH_FINISHED |=>
            phase == lfrc_pkg::PH_FINISHED)
        else $error("route left the finished phase");

    // Every accepted sensor beat leaves a result beat pending
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> o_m_axis_tvalid)
        else $error("accepted sensor beat left no result");

endmodule

bind line_follower_route_controller_core lfrc_checker u_lfrc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int PWM_PERIOD  = 20;
    localparam int TURN_LINE   = 8;
    localparam int FINISH_LINE = 16;
    localparam int QUIET_LIMIT = 2000;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = '0;   // [0] left_sensor, [1] right_sensor
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;         // [0] left_pwm, [1] right_pwm, [3:2] left_dir,
                                         // [5:4] right_dir, [10:6] line_count, [13:11] phase
    logic        i_cfg_we        = 1'b0;
    lfrc_pkg::t_cfg_idx i_cfg_index = lfrc_pkg::CFG_CRUISE_SPEED;
    logic [31:0] i_cfg_data      = '0;

    line_follower_route_controller_core #(
        .PWM_PERIOD      (PWM_PERIOD),
        .TURNAROUND_LINE (TURN_LINE),
        .FINISH_LINE     (FINISH_LINE)
    ) uut (.*);

    // Expected result beats, oldest first
    lfrc_pkg::t_result tick_results[$];
    int      mismatches = 0;
    bit      steady     = 1'b0;   // no random gaps on either side while set
    int      sink_hold  = 0;      // cycles the result side is to hold off

    // Controller settings as the block should hold them
    logic [4:0]  cfg_cruise   = lfrc_pkg::RST_CRUISE_SPEED;
    logic [4:0]  cfg_inner    = lfrc_pkg::RST_INNER_SPEED;
    logic [4:0]  cfg_outer    = lfrc_pkg::RST_OUTER_SPEED;
    logic [11:0] cfg_uturn    = lfrc_pkg::RST_U_TURN_TICKS;
    logic [11:0] cfg_pivot    = lfrc_pkg::RST_PIVOT_TICKS;
    logic [7:0]  cfg_debounce = lfrc_pkg::RST_DEBOUNCE_TICKS;
    logic [7:0]  cfg_cooldown = lfrc_pkg::RST_COOLDOWN_TICKS;
    logic [31:0] cfg_mask     = lfrc_pkg::RST_PIVOT_LINE_MASK;

    // Route, crossing and PWM state as the block should hold it
    logic [4:0]  pwm_cnt     = '0;
    logic [4:0]  drv_l       = '0;
    logic [4:0]  drv_r       = '0;
    lfrc_pkg::t_dir dir_l    = lfrc_pkg::DIR_STOP;
    lfrc_pkg::t_dir dir_r    = lfrc_pkg::DIR_STOP;
    logic [4:0]  lines       = '0;
    logic        seen_black  = 1'b0;
    logic        counted     = 1'b0;
    logic [7:0]  deb_cnt     = '0;
    logic [7:0]  cool_cnt    = '0;
    logic        uturn_on    = 1'b0;
    logic [11:0] uturn_tmr   = '0;
    logic        pivot_on    = 1'b0;
    logic [11:0] pivot_tmr   = '0;
    logic        homebound   = 1'b0;
    logic        pivot_taken = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic route_finished();
        return homebound && (lines >= 5'(FINISH_LINE));
    endfunction

    function automatic logic pivot_line(input logic [4:0] line_no);
        return cfg_mask[line_no];
    endfunction

    function automatic void set_drive(input logic [4:0] ld, input logic [4:0] rd,
                                      input lfrc_pkg::t_dir ldir,
                                      input lfrc_pkg::t_dir rdir);
        drv_l = ld;
        drv_r = rd;
        dir_l = ldir;
        dir_r = rdir;
    endfunction

    function automatic void forget_crossing();
        seen_black = 1'b0;
        counted    = 1'b0;
        deb_cnt    = '0;
        cool_cnt   = '0;
    endfunction

    // Advance the controller by one tick and return the beat it should give
    function automatic lfrc_pkg::t_result advance_route_tick(input logic sl, input logic sr);
        lfrc_pkg::t_result res;
        res = '0;

        // PWM level compares against the drive of the previous tick
        pwm_cnt       = pwm_cnt + 5'd1;
        res.left_pwm  = (pwm_cnt <= drv_l);
        res.right_pwm = (pwm_cnt <= drv_r);
        if (pwm_cnt >= 5'(PWM_PERIOD))
            pwm_cnt = '0;

        if (!route_finished()) begin
            if (uturn_on) begin
                set_drive(cfg_cruise, cfg_cruise, lfrc_pkg::DIR_FWD, lfrc_pkg::DIR_BACK);
                uturn_tmr = uturn_tmr + 12'd1;
                if (uturn_tmr >= cfg_uturn || uturn_tmr == '0) begin
                    uturn_on  = 1'b0;
                    homebound = 1'b1;
                end
            end else if (pivot_on) begin
                set_drive(cfg_cruise, cfg_cruise, lfrc_pkg::DIR_BACK, lfrc_pkg::DIR_FWD);
                pivot_tmr = pivot_tmr + 12'd1;
                if (pivot_tmr >= cfg_pivot || pivot_tmr == '0) begin
                    pivot_on  = 1'b0;
                    pivot_tmr = '0;
                    forget_crossing();
                end
            end else if (!sl && !sr) begin
                set_drive(cfg_cruise, cfg_cruise, lfrc_pkg::DIR_FWD, lfrc_pkg::DIR_FWD);
                seen_black = 1'b1;
                counted    = 1'b0;
                deb_cnt    = '0;
            end else if (!sl) begin
                set_drive(cfg_outer, cfg_inner, lfrc_pkg::DIR_FWD, lfrc_pkg::DIR_BACK);
                counted = 1'b0;
                deb_cnt = '0;
            end else if (!sr) begin
                set_drive(cfg_inner, cfg_outer, lfrc_pkg::DIR_BACK, lfrc_pkg::DIR_FWD);
                counted = 1'b0;
                deb_cnt = '0;
            end else begin
                // Both white: cooldown first, then debounce towards a count
                set_drive(cfg_cruise, cfg_cruise, lfrc_pkg::DIR_FWD, lfrc_pkg::DIR_FWD);
                if (cool_cnt > 8'd0) begin
                    cool_cnt = cool_cnt - 8'd1;
                    deb_cnt  = '0;
                end else if (seen_black && !counted) begin
                    if (deb_cnt < lfrc_pkg::DEBOUNCE_MAX)
                        deb_cnt = deb_cnt + 8'd1;
                    if (deb_cnt >= cfg_debounce) begin
                        if (lines < lfrc_pkg::CROSS_MAX)
                            lines = lines + 5'd1;
                        seen_black = 1'b0;
                        counted    = 1'b1;
                        cool_cnt   = cfg_cooldown;
                        deb_cnt    = '0;
                        if (!homebound && lines >= 5'(TURN_LINE)) begin
                            uturn_on  = 1'b1;
                            uturn_tmr = '0;
                            forget_crossing();
                        end else if (homebound && !pivot_taken && pivot_line(lines)) begin
                            pivot_on    = 1'b1;
                            pivot_tmr   = '0;
                            pivot_taken = 1'b1;
                        end
                        if (!pivot_line(lines))
                            pivot_taken = 1'b0;
                    end
                end else if (!seen_black) begin
                    deb_cnt = '0;
                end
            end
        end
        if (route_finished())
            set_drive('0, '0, lfrc_pkg::DIR_STOP, lfrc_pkg::DIR_STOP);

        res.left_dir   = dir_l;
        res.right_dir  = dir_r;
        res.line_count = lines;
        if (route_finished())
            res.phase = lfrc_pkg::PH_FINISHED;
        else if (uturn_on)
            res.phase = lfrc_pkg::PH_TURNAROUND;
        else if (pivot_on)
            res.phase = lfrc_pkg::PH_PIVOT;
        else if (homebound)
            res.phase = lfrc_pkg::PH_RETURN;
        else
            res.phase = lfrc_pkg::PH_OUTBOUND;
        return res;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_result(input lfrc_pkg::t_result got);
        lfrc_pkg::t_result want;
        if (tick_results.size() == 0) begin
            mismatches++;
            $display("%0t ns: result beat with none expected, expected nothing, got %h",
                     $time, got);
        end else begin
            want = tick_results.pop_front();
            compare_field("left_pwm", 32'(want.left_pwm), 32'(got.left_pwm));
            compare_field("right_pwm", 32'(want.right_pwm), 32'(got.right_pwm));
            compare_field("left_dir", 32'(want.left_dir), 32'(got.left_dir));
            compare_field("right_dir", 32'(want.right_dir), 32'(got.right_dir));
            compare_field("line_count", 32'(want.line_count), 32'(got.line_count));
            compare_field("phase", int'(want.phase), int'(got.phase));
            compare_field("pad", 32'(want.pad), 32'(got.pad));
        end
    endtask

    // Result side: stall at random after each beat unless steady, honour long hold-offs
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_m_axis_tready && o_m_axis_tvalid) begin
                check_result(lfrc_pkg::t_result'(o_m_axis_tdata));
                stall = steady ? 0 : $urandom_range(0, 19);
            end
            if (sink_hold > 0) begin
                sink_hold--;
                i_m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Abort when neither side moves a beat for too long
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL line_follower_route_controller_core");
        $finish;
    end

    // Offer one sensor beat after a random gap unless steady; valid stays up until the next gap or a settle
    task automatic send_sensors(input logic sl, input logic sr);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'b0, sr, sl};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        tick_results.push_back(advance_route_tick(sl, sr));
    endtask

    task automatic send_noise(input int count);
        logic [1:0] bits;
        repeat (count) begin
            bits = 2'($urandom_range(0, 3));
            send_sensors(bits[0], bits[1]);
        end
    endtask

    // Drop valid and wait for every outstanding result beat
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (tick_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input lfrc_pkg::t_cfg_idx idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            lfrc_pkg::CFG_CRUISE_SPEED:   cfg_cruise   = val[4:0];
            lfrc_pkg::CFG_INNER_SPEED:    cfg_inner    = val[4:0];
            lfrc_pkg::CFG_OUTER_SPEED:    cfg_outer    = val[4:0];
            lfrc_pkg::CFG_U_TURN_TICKS:   cfg_uturn    = val[11:0];
            lfrc_pkg::CFG_PIVOT_TICKS:    cfg_pivot    = val[11:0];
            lfrc_pkg::CFG_DEBOUNCE_TICKS: cfg_debounce = val[7:0];
            lfrc_pkg::CFG_COOLDOWN_TICKS: cfg_cooldown = val[7:0];
            default:                      cfg_mask     = val;
        endcase
    endtask

    task automatic load_config(input logic [4:0] cruise, input logic [4:0] inner,
                               input logic [4:0] outer, input logic [11:0] uturn,
                               input logic [11:0] pivot, input logic [7:0] deb,
                               input logic [7:0] cool, input logic [31:0] mask);
        write_reg(lfrc_pkg::CFG_CRUISE_SPEED, 32'(cruise));
        write_reg(lfrc_pkg::CFG_INNER_SPEED, 32'(inner));
        write_reg(lfrc_pkg::CFG_OUTER_SPEED, 32'(outer));
        write_reg(lfrc_pkg::CFG_U_TURN_TICKS, 32'(uturn));
        write_reg(lfrc_pkg::CFG_PIVOT_TICKS, 32'(pivot));
        write_reg(lfrc_pkg::CFG_DEBOUNCE_TICKS, 32'(deb));
        write_reg(lfrc_pkg::CFG_COOLDOWN_TICKS, 32'(cool));
        write_reg(lfrc_pkg::CFG_PIVOT_LINE_MASK, mask);
    endtask

    // One black stretch then enough white to count it, sometimes broken by a side beat
    task automatic drive_crossing();
        int   white_len;
        int   break_at;
        logic side;
        repeat ($urandom_range(1, 6)) send_sensors(1'b0, 1'b0);
        white_len = cool_cnt + cfg_debounce + $urandom_range(0, 4);
        break_at  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, white_len) : -1;
        for (int k = 0; k < white_len; k++) begin
            if (k == break_at) begin
                side = 1'($urandom_range(0, 1));
                send_sensors(side, !side);
            end
            send_sensors(1'b1, 1'b1);
        end
    endtask

    // Every sensor pair at reset settings, then a full debounce to a first count
    task automatic test_sensor_cases();
        send_sensors(1'b1, 1'b1);
        send_sensors(1'b0, 1'b1);
        send_sensors(1'b1, 1'b0);
        send_sensors(1'b0, 1'b0);
        send_sensors(1'b0, 1'b0);
        repeat (20) send_sensors(1'b1, 1'b1);
        settle();
    endtask

    // Register extremes under noise, with a debounce too long for noise to count
    task automatic test_config_extremes();
        load_config(5'd31, 5'd31, 5'd31, 12'd4095, 12'd4095, 8'd255, 8'd255, 32'hFFFF_FFFF);
        send_noise(120);
        settle();
        load_config(5'd0, 5'd0, 5'd0, 12'd1, 12'd1, 8'd255, 8'd0, 32'h0);
        send_noise(120);
        settle();
        // Zero debounce: run out any cooldown, then the first white beat counts
        write_reg(lfrc_pkg::CFG_DEBOUNCE_TICKS, 32'd0);
        repeat (cool_cnt) send_sensors(1'b1, 1'b1);
        send_sensors(1'b0, 1'b0);
        send_sensors(1'b1, 1'b1);
        send_sensors(1'b1, 1'b1);
        settle();
    endtask

    // Hold the result side off while sensor beats keep coming, then run gapless
    task automatic test_result_backpressure();
        load_config(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                    5'($urandom_range(0, 31)), 12'($urandom_range(1, 4095)),
                    12'($urandom_range(1, 4095)), 8'd255,
                    8'($urandom_range(0, 255)), $urandom());
        steady    = 1'b1;
        sink_hold = 300;
        send_noise(120);
        steady = 1'b0;
        settle();
    endtask

    // Full route: outbound, turnaround, return with pivots, finish
    task automatic test_route_run();
        int                 tries;
        lfrc_pkg::t_cfg_idx pick;
        load_config(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                    5'($urandom_range(0, 31)), 12'd0, 12'd0,
                    8'($urandom_range(1, 30)), 8'($urandom_range(0, 60)), $urandom());
        tries = 0;
        while (!route_finished() && tries < 400) begin
            drive_crossing();
            if ($urandom_range(0, 7) == 0)
                send_noise($urandom_range(1, 6));
            // Now and then retune one register between crossings
            if ($urandom_range(0, 3) == 0) begin
                settle();
                pick = lfrc_pkg::t_cfg_idx'($urandom_range(0, 7));
                case (pick)
                    lfrc_pkg::CFG_CRUISE_SPEED, lfrc_pkg::CFG_INNER_SPEED,
                    lfrc_pkg::CFG_OUTER_SPEED:
                        write_reg(pick, $urandom_range(0, 31));
                    lfrc_pkg::CFG_U_TURN_TICKS:   write_reg(pick, $urandom_range(0, 120));
                    lfrc_pkg::CFG_PIVOT_TICKS:    write_reg(pick, $urandom_range(0, 60));
                    lfrc_pkg::CFG_DEBOUNCE_TICKS: write_reg(pick, $urandom_range(0, 30));
                    lfrc_pkg::CFG_COOLDOWN_TICKS: write_reg(pick, $urandom_range(0, 60));
                    default:                      write_reg(pick, $urandom());
                endcase
            end
            tries++;
        end
        settle();
    endtask

    // After the finish line the stop must hold whatever the sensors and settings do
    task automatic test_finished_hold();
        send_noise(100);
        settle();
        load_config(5'd31, 5'd31, 5'd31, 12'd1, 12'd1, 8'd1, 8'd0, 32'hFFFF_FFFF);
        send_noise(60);
        settle();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_sensor_cases();
        test_config_extremes();
        test_result_backpressure();
        test_route_run();
        test_finished_hold();
        if (mismatches == 0 && tick_results.size() == 0)
            $display("PASS line_follower_route_controller_core");
        else
            $display("FAIL line_follower_route_controller_core");
        $finish;
    end

endmodule
